@@ src/mpbm_pkg.sv @@
`timescale 1ns / 1ps
package mpbm_pkg;

  localparam int TDATA_W = 16;

  typedef enum logic [1:0] {
    FUNC_PAT     = 2'd0,
    FUNC_END     = 2'd1,
    FUNC_SCAN    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

endpackage

@@ src/mpbm_ram.sv @@
`timescale 1ns / 1ps
module mpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/multi_pattern_byte_matcher_top.sv @@
`timescale 1ns / 1ps
// one word at a time; a pattern byte reads the child table, a scan byte reads it again per
//   failure link followed; end pattern, restart and a pattern byte after overflow skip it
// the first scan byte after a pattern or end word also rebuilds the failure links, a walk
//   over every (node, byte) pair of the child table
// reset (rst_n low, synchronous) clears the child table and the terminal marks, with
//   in_tready low, before the first word is taken
module multi_pattern_byte_matcher_top #(
  parameter int MAX_STATES = 256,
  parameter int ALPHABET   = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mpbm_pkg::TDATA_W-1:0] in_tdata,   // func[1:0], data_byte[9:2]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mpbm_pkg::TDATA_W-1:0] out_tdata   // match[0], node[8:1], status[9]
);

  localparam int NW    = $clog2(MAX_STATES);
  localparam int CW    = $clog2(ALPHABET);
  localparam int AW    = $clog2(MAX_STATES * ALPHABET);
  localparam int CNT_W = NW + 1;
  localparam int LW    = NW + 1;
  localparam int CLR_W = AW + 1;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DONE, ST_PB_RD, ST_PB_CHK,
    ST_SC_RD, ST_SC_CHK, ST_SC_FL, ST_SC_HIT,
    ST_RB_INIT, ST_RB_NODE, ST_RB_QV, ST_RB_FV, ST_RB_CRD, ST_RB_CCHK,
    ST_RB_FCHK, ST_RB_FF, ST_RB_SH
  } state_t;

  state_t state_r, state_nxt;

  logic [CLR_W-1:0]      clr_r, clr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [NW-1:0]         load_r, load_nxt;
  logic [NW-1:0]         scan_r, scan_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  stale_r, stale_nxt;
  logic [CW-1:0]         b_r, b_nxt;
  logic [NW-1:0]         v_r, v_nxt;
  logic [NW-1:0]         fv_r, fv_nxt;
  logic [NW-1:0]         u_r, u_nxt;
  logic [NW-1:0]         f_r, f_nxt;
  logic [CW-1:0]         c_r, c_nxt;
  logic [CNT_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      tail_r, tail_nxt;
  logic                  res_match_r, res_match_nxt;
  logic [NW-1:0]         res_node_r, res_node_nxt;
  logic                  res_stat_r, res_stat_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [mpbm_pkg::TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // child table
  logic [NW-1:0] cn;
  logic [CW-1:0] cc;
  logic [AW-1:0] child_addr, child_waddr;
  logic          child_we;
  logic [NW-1:0] child_wdata, child_rd;

  // failure link and suffix hit, {hit, fail}
  logic          link_we;
  logic [NW-1:0] link_waddr, link_raddr;
  logic [LW-1:0] link_wdata, link_rd;
  logic [NW-1:0] link_fail;
  logic          link_hit;

  // terminal marks
  logic          term_we;
  logic [NW-1:0] term_waddr, term_raddr;
  logic          term_wdata, term_rd;

  // breadth-first queue
  logic          q_we;
  logic [NW-1:0] q_rd;

  logic [CW-1:0] mod_tab [256];
  logic          accept;
  mpbm_pkg::func_t in_func;
  logic [CW-1:0] in_char;

  for (genvar gi = 0; gi < 256; gi++) begin : g_mod
    assign mod_tab[gi] = CW'(gi % ALPHABET);
  end

  assign accept    = in_tvalid && in_tready;
  assign in_func   = mpbm_pkg::func_t'(in_tdata[1:0]);
  assign in_char   = mod_tab[in_tdata[9:2]];
  assign in_tready = (state_r == ST_IDLE);
  assign link_fail = link_rd[NW-1:0];
  assign link_hit  = link_rd[NW];

  assign child_addr  = AW'(cn) * AW'(ALPHABET) + AW'(cc);
  assign child_waddr = (state_r == ST_CLR) ? clr_r[AW-1:0] : child_addr;

  mpbm_ram #(.WIDTH(NW), .DEPTH(MAX_STATES * ALPHABET)) u_child (
    .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
    .raddr(child_addr), .rdata(child_rd)
  );

  mpbm_ram #(.WIDTH(LW), .DEPTH(MAX_STATES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rd)
  );

  mpbm_ram #(.WIDTH(1), .DEPTH(MAX_STATES)) u_term (
    .clk(clk), .we(term_we), .waddr(term_waddr), .wdata(term_wdata),
    .raddr(term_raddr), .rdata(term_rd)
  );

  mpbm_ram #(.WIDTH(NW), .DEPTH(MAX_STATES)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail_r[NW-1:0]), .wdata(u_r),
    .raddr(head_r[NW-1:0]), .rdata(q_rd)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    count_nxt      = count_r;
    load_nxt       = load_r;
    scan_nxt       = scan_r;
    ovf_nxt        = ovf_r;
    stale_nxt      = stale_r;
    b_nxt          = b_r;
    v_nxt          = v_r;
    fv_nxt         = fv_r;
    u_nxt          = u_r;
    f_nxt          = f_r;
    c_nxt          = c_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    res_match_nxt  = res_match_r;
    res_node_nxt   = res_node_r;
    res_stat_nxt   = res_stat_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    cn             = load_r;
    cc             = b_r;
    child_we       = 1'b0;
    child_wdata    = '0;
    link_we        = 1'b0;
    link_waddr     = u_r;
    link_wdata     = '0;
    link_raddr     = '0;
    // root mark is read by default so it is ready in idle
    term_we        = 1'b0;
    term_waddr     = load_r;
    term_wdata     = 1'b0;
    term_raddr     = '0;
    q_we           = 1'b0;

    unique case (state_r)
      ST_CLR: begin
        child_we   = 1'b1;
        term_we    = 1'b1;
        term_waddr = clr_r[NW-1:0];
        clr_nxt    = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(MAX_STATES * ALPHABET - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          b_nxt = in_char;
          res_match_nxt = 1'b0;
          unique case (in_func)
            mpbm_pkg::FUNC_PAT: begin
              if (ovf_r) begin
                res_node_nxt = load_r;
                res_stat_nxt = 1'b1;
                scan_nxt     = '0;
                stale_nxt    = 1'b1;
                state_nxt    = ST_DONE;
              end else begin
                state_nxt = ST_PB_RD;
              end
            end
            mpbm_pkg::FUNC_END: begin
              res_node_nxt = load_r;
              res_stat_nxt = ovf_r;
              if (!ovf_r) begin
                term_we    = 1'b1;
                term_wdata = 1'b1;
              end
              ovf_nxt   = 1'b0;
              load_nxt  = '0;
              scan_nxt  = '0;
              stale_nxt = 1'b1;
              state_nxt = ST_DONE;
            end
            mpbm_pkg::FUNC_SCAN: begin
              state_nxt = stale_r ? ST_RB_INIT : ST_SC_RD;
            end
            mpbm_pkg::FUNC_RESTART: begin
              scan_nxt      = '0;
              res_node_nxt  = '0;
              res_match_nxt = term_rd;
              res_stat_nxt  = ovf_r;
              state_nxt     = ST_DONE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = '0;
          out_tdata_nxt[0]   = res_match_r;
          out_tdata_nxt[8:1] = 8'(res_node_r);
          out_tdata_nxt[9]   = res_stat_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_PB_RD: begin
        state_nxt = ST_PB_CHK;
      end
      ST_PB_CHK: begin
        res_stat_nxt = 1'b0;
        if (child_rd != '0) begin
          load_nxt     = child_rd;
          res_node_nxt = child_rd;
        end else if (count_r < CNT_W'(MAX_STATES)) begin
          child_we     = 1'b1;
          child_wdata  = count_r[NW-1:0];
          load_nxt     = count_r[NW-1:0];
          res_node_nxt = count_r[NW-1:0];
          count_nxt    = count_r + CNT_W'(1);
        end else begin
          ovf_nxt      = 1'b1;
          res_node_nxt = load_r;
          res_stat_nxt = 1'b1;
        end
        scan_nxt  = '0;
        stale_nxt = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SC_RD: begin
        cn = scan_r;
        state_nxt = ST_SC_CHK;
      end
      ST_SC_CHK: begin
        if (scan_r != '0 && child_rd == '0) begin
          link_raddr = scan_r;
          state_nxt  = ST_SC_FL;
        end else begin
          scan_nxt   = child_rd;
          link_raddr = child_rd;
          state_nxt  = ST_SC_HIT;
        end
      end
      ST_SC_FL: begin
        scan_nxt  = link_fail;
        cn        = link_fail;
        state_nxt = ST_SC_CHK;
      end
      ST_SC_HIT: begin
        res_match_nxt = link_hit;
        res_node_nxt  = scan_r;
        res_stat_nxt  = ovf_r;
        state_nxt     = ST_DONE;
      end
      ST_RB_INIT: begin
        link_we    = 1'b1;
        link_waddr = '0;
        link_wdata = {term_rd, {NW{1'b0}}};
        head_nxt   = '0;
        tail_nxt   = CNT_W'(1);
        c_nxt      = '0;
        state_nxt  = ST_RB_NODE;
      end
      ST_RB_NODE: begin
        c_nxt = '0;
        if (head_r == tail_r) begin
          stale_nxt = 1'b0;
          state_nxt = ST_SC_RD;
        end else if (head_r == '0) begin
          v_nxt     = '0;
          head_nxt  = head_r + CNT_W'(1);
          state_nxt = ST_RB_CRD;
        end else begin
          state_nxt = ST_RB_QV;
        end
      end
      ST_RB_QV: begin
        v_nxt      = q_rd;
        head_nxt   = head_r + CNT_W'(1);
        link_raddr = q_rd;
        state_nxt  = ST_RB_FV;
      end
      ST_RB_FV: begin
        fv_nxt    = link_fail;
        state_nxt = ST_RB_CRD;
      end
      ST_RB_CRD: begin
        cn = v_r;
        cc = c_r;
        state_nxt = ST_RB_CCHK;
      end
      ST_RB_CCHK: begin
        cn = fv_r;
        cc = c_r;
        if (child_rd == '0) begin
          if (c_r == CW'(ALPHABET - 1)) begin
            state_nxt = ST_RB_NODE;
          end else begin
            c_nxt     = c_r + CW'(1);
            state_nxt = ST_RB_CRD;
          end
        end else begin
          u_nxt      = child_rd;
          term_raddr = child_rd;
          if (v_r == '0) begin
            f_nxt      = '0;
            link_raddr = '0;
            state_nxt  = ST_RB_SH;
          end else begin
            f_nxt     = fv_r;
            state_nxt = ST_RB_FCHK;
          end
        end
      end
      ST_RB_FCHK: begin
        term_raddr = u_r;
        if (f_r != '0 && child_rd == '0) begin
          link_raddr = f_r;
          state_nxt  = ST_RB_FF;
        end else begin
          f_nxt      = child_rd;
          link_raddr = child_rd;
          state_nxt  = ST_RB_SH;
        end
      end
      ST_RB_FF: begin
        term_raddr = u_r;
        f_nxt      = link_fail;
        cn         = link_fail;
        cc         = c_r;
        state_nxt  = ST_RB_FCHK;
      end
      ST_RB_SH: begin
        link_we    = 1'b1;
        link_waddr = u_r;
        link_wdata = {term_rd | link_hit, f_r};
        q_we       = 1'b1;
        tail_nxt   = tail_r + CNT_W'(1);
        if (c_r == CW'(ALPHABET - 1)) begin
          state_nxt = ST_RB_NODE;
        end else begin
          c_nxt     = c_r + CW'(1);
          state_nxt = ST_RB_CRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      count_r      <= CNT_W'(1);
      load_r       <= '0;
      scan_r       <= '0;
      ovf_r        <= 1'b0;
      stale_r      <= 1'b1;
      head_r       <= '0;
      tail_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      count_r      <= count_nxt;
      load_r       <= load_nxt;
      scan_r       <= scan_nxt;
      ovf_r        <= ovf_nxt;
      stale_r      <= stale_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    b_r         <= b_nxt;
    v_r         <= v_nxt;
    fv_r        <= fv_nxt;
    u_r         <= u_nxt;
    f_r         <= f_nxt;
    c_r         <= c_nxt;
    res_match_r <= res_match_nxt;
    res_node_r  <= res_node_nxt;
    res_stat_r  <= res_stat_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ src/mpbm_checker.sv @@
`timescale 1ns / 1ps
module mpbm_port_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [mpbm_pkg::TDATA_W-1:0] in_tdata,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [mpbm_pkg::TDATA_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no accept in the cycle right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // padding bits of a result word stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:10] == 6'd0)
    else $error("result padding not zero");

  // reset empties the output and blocks input during the clear pass
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

endmodule

bind multi_pattern_byte_matcher_top mpbm_port_checker u_mpbm_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ tb/mpbm_checker.sv @@
`timescale 1ns / 1ps
module mpbm_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [mpbm_pkg::TDATA_W-1:0] in_tdata,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [mpbm_pkg::TDATA_W-1:0] out_tdata,
  output int                           errors,
  output int                           pending,
  output int                           results,
  output int                           hits
);

  typedef struct packed {
    logic       match;
    logic [7:0] node;
    logic       status;
  } scan_res_t;

  logic [8:0] trie_kid [0:65535];
  logic [7:0] fail_of [0:255];
  bit         is_term [0:255];
  bit         sfx_hit [0:255];
  int         node_total;
  logic [7:0] load_pos;
  logic [7:0] scan_pos;
  bit         dropped;
  bit         links_old;
  scan_res_t  expected_q [$];

  function automatic int kid_of(int v, int c);
    return int'(trie_kid[v * 256 + c]);
  endfunction

  // breadth-first walk that recomputes failure links and dictionary-suffix hits
  function automatic void relink();
    int order [$];
    int v;
    int u;
    int f;
    fail_of[0] = 8'd0;
    sfx_hit[0] = is_term[0];
    order.push_back(0);
    while (order.size() > 0) begin
      v = order.pop_front();
      for (int c = 0; c < 256; c++) begin
        u = kid_of(v, c);
        if (u == 0) continue;
        f = 0;
        if (v != 0) begin
          f = int'(fail_of[v]);
          while (f != 0 && kid_of(f, c) == 0) f = int'(fail_of[f]);
          f = kid_of(f, c);
        end
        fail_of[u] = f[7:0];
        sfx_hit[u] = is_term[u] | sfx_hit[f];
        order.push_back(u);
      end
    end
    links_old = 0;
  endfunction

  function automatic scan_res_t advance(mpbm_pkg::func_t fn, logic [7:0] b);
    scan_res_t r;
    int u;
    int v;
    r = '0;
    case (fn)
      mpbm_pkg::FUNC_PAT: begin
        if (!dropped) begin
          u = kid_of(int'(load_pos), int'(b));
          if (u == 0) begin
            if (node_total < 256) begin
              trie_kid[int'(load_pos) * 256 + int'(b)] = node_total[8:0];
              load_pos = node_total[7:0];
              node_total++;
            end else begin
              dropped = 1;
            end
          end else begin
            load_pos = u[7:0];
          end
        end
        scan_pos = 8'd0;
        links_old = 1;
        r.node = load_pos;
        r.status = dropped;
      end
      mpbm_pkg::FUNC_END: begin
        r.node = load_pos;
        r.status = dropped;
        if (!dropped) is_term[load_pos] = 1;
        dropped = 0;
        load_pos = 8'd0;
        scan_pos = 8'd0;
        links_old = 1;
      end
      default: begin
        if (links_old) relink();
        if (fn == mpbm_pkg::FUNC_SCAN) begin
          v = int'(scan_pos);
          while (v != 0 && kid_of(v, int'(b)) == 0) v = int'(fail_of[v]);
          scan_pos = 8'(kid_of(v, int'(b)));
        end else begin
          scan_pos = 8'd0;
        end
        r.node = scan_pos;
        r.match = sfx_hit[scan_pos];
        r.status = dropped;
      end
    endcase
    return r;
  endfunction

  initial begin
    for (int i = 0; i < 65536; i++) trie_kid[i] = '0;
    for (int i = 0; i < 256; i++) begin
      fail_of[i] = '0;
      is_term[i] = 0;
      sfx_hit[i] = 0;
    end
    node_total = 1;
    load_pos = 8'd0;
    scan_pos = 8'd0;
    dropped = 0;
    links_old = 1;
    errors = 0;
    pending = 0;
    results = 0;
    hits = 0;
  end

  always @(posedge clk) begin
    scan_res_t want;
    scan_res_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{match: out_tdata[0], node: out_tdata[8:1], status: out_tdata[9]};
        results++;
        if (got.match) hits++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: match %b/%b node %0d/%0d status %b/%b (exp/got)",
                       results, want.match, got.match, want.node, got.node,
                       want.status, got.status);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(advance(mpbm_pkg::func_t'(in_tdata[1:0]), in_tdata[9:2]));
      pending = expected_q.size();
    end
  end
endmodule

@@ tb/tb_multi_pattern_byte_matcher_top.sv @@
`timescale 1ns / 1ps
module tb_multi_pattern_byte_matcher_top;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [mpbm_pkg::TDATA_W-1:0] in_tdata;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [mpbm_pkg::TDATA_W-1:0] out_tdata;
  int                           errors;
  int                           pending;
  int                           results;
  int                           hits;
  int                           words_sent;
  bit                           no_gaps;

  multi_pattern_byte_matcher_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  mpbm_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending), .results(results), .hits(hits)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (no_gaps || r < 55) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  task automatic send(mpbm_pkg::func_t fn, logic [7:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, b, fn};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (words_sent % 200 == 0) no_gaps = ($urandom_range(0, 3) == 0);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly a small alphabet so text runs into loaded patterns
  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 9) < 8) return 8'h61 + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic load_word(int len, bit wide);
    for (int i = 0; i < len; i++)
      send(mpbm_pkg::FUNC_PAT, wide ? 8'($urandom_range(0, 255)) : text_byte());
    send(mpbm_pkg::FUNC_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic scan_run(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 7) send(mpbm_pkg::FUNC_RESTART, 8'($urandom_range(0, 255)));
      else send(mpbm_pkg::FUNC_SCAN, text_byte());
    end
  endtask

  // receiver: random backpressure plus one long hold-off
  initial begin
    bit held;
    held = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results >= 150) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (no_gaps) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  initial begin
    #60ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    words_sent = 0;
    no_gaps = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: small patterns, field extremes, loading while scanning
    send(mpbm_pkg::FUNC_PAT, 8'h61); send(mpbm_pkg::FUNC_PAT, 8'h62);
    send(mpbm_pkg::FUNC_END, 8'hff);
    send(mpbm_pkg::FUNC_PAT, 8'h62); send(mpbm_pkg::FUNC_END, 8'h00);
    send(mpbm_pkg::FUNC_PAT, 8'h00); send(mpbm_pkg::FUNC_PAT, 8'hff);
    send(mpbm_pkg::FUNC_END, 8'h00);
    send(mpbm_pkg::FUNC_SCAN, 8'h61); send(mpbm_pkg::FUNC_SCAN, 8'h62);
    send(mpbm_pkg::FUNC_SCAN, 8'h61);
    send(mpbm_pkg::FUNC_SCAN, 8'h62); send(mpbm_pkg::FUNC_SCAN, 8'h63);
    send(mpbm_pkg::FUNC_SCAN, 8'h00);
    send(mpbm_pkg::FUNC_SCAN, 8'hff); send(mpbm_pkg::FUNC_RESTART, 8'hff);
    send(mpbm_pkg::FUNC_SCAN, 8'h62);
    send(mpbm_pkg::FUNC_SCAN, 8'h61);
    send(mpbm_pkg::FUNC_PAT, 8'h63);
    send(mpbm_pkg::FUNC_SCAN, 8'h61); send(mpbm_pkg::FUNC_SCAN, 8'h62);
    send(mpbm_pkg::FUNC_PAT, 8'h64); send(mpbm_pkg::FUNC_END, 8'h55);
    send(mpbm_pkg::FUNC_SCAN, 8'h63); send(mpbm_pkg::FUNC_SCAN, 8'h64);

    // growing dictionaries, each followed by a long text
    for (int ph = 0; ph < 3; ph++) begin
      for (int k = 0; k < 4 + 4 * ph; k++) load_word(int'($urandom_range(1, 6)), 0);
      scan_run(300);
    end

    // fill the trie past its capacity with long random words
    for (int k = 0; k < 13; k++) load_word(20, 1);
    scan_run(200);

    // empty pattern marks the root, so every position hits
    send(mpbm_pkg::FUNC_END, 8'h00);
    scan_run(30);
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d with a pattern hit",
             words_sent, results, hits);
    $display("dictionary grown in steps to a full trie with overflow and an empty pattern");
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ files.f @@
src/mpbm_pkg.sv
src/mpbm_ram.sv
src/multi_pattern_byte_matcher_top.sv
src/mpbm_checker.sv
tb/mpbm_checker.sv
tb/tb_multi_pattern_byte_matcher_top.sv
